@@ hdl/isl_pkg.sv @@
// Shared types and codes for the indexed shift list.
package isl_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int DATA_W = 32;
	localparam int INDEX_W = 9;
	localparam int COUNT_W = 9;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_INSERT  = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_POP     = 3'd3,
		OP_REPLACE = 3'd4,
		OP_GET     = 3'd5
	} isl_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} isl_status_t;

	// What each cell does with its entry this cycle
	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_INS,
		MODE_DEL,
		MODE_WR
	} isl_mode_t;

	typedef struct packed {
		isl_mode_t mode;
		logic      rd;
	} isl_cell_ctrl_t;

	typedef struct packed {
		logic [2:0]               op;
		logic [INDEX_W-1:0]       index;
		logic signed [DATA_W-1:0] value;
	} isl_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [1:0]               status;
		logic [COUNT_W-1:0]       count;
	} isl_rsp_t;

endpackage

@@ hdl/isl_cell.sv @@
// One list entry: shifts with its neighbors, takes writes, offers a masked read leaf.
module isl_cell import isl_pkg::*; #(
	parameter int PW  = 9,
	parameter int POS = 0
) (
	input  logic                 clk,
	input  isl_cell_ctrl_t       ctrl,
	input  logic [PW-1:0]        pos,
	input  logic [DATA_W-1:0]    value,
	input  logic [DATA_W-1:0]    left,
	input  logic [DATA_W-1:0]    right,
	output logic [DATA_W-1:0]    data,
	output logic [DATA_W-1:0]    leaf
);

	localparam logic [PW-1:0] MY_POS = PW'(POS);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] leaf_q;
	logic              at_pos;
	logic              above_pos;

	assign at_pos    = (pos == MY_POS);
	assign above_pos = (MY_POS > pos);

	always_ff @(posedge clk) begin
		case (ctrl.mode)
			MODE_INS: begin
				if (above_pos)
					data_q <= left;
				else if (at_pos)
					data_q <= value;
			end
			MODE_DEL: begin
				if (above_pos || at_pos)
					data_q <= right;
			end
			MODE_WR: begin
				if (at_pos)
					data_q <= value;
			end
			default: ;
		endcase
		// zero unless this cell is the one being read, so the tree can OR
		leaf_q <= (ctrl.rd && at_pos) ? data_q : '0;
	end

	assign data = data_q;
	assign leaf = leaf_q;

endmodule

@@ hdl/isl_or_tree.sv @@
// Registered 4-ary OR tree that gathers the one nonzero read leaf.
module isl_or_tree #(
	parameter int W      = 32,
	parameter int LEAVES = 256,
	parameter int LEVELS = 4
) (
	input  logic                     clk,
	input  logic [LEAVES-1:0][W-1:0] leaf,
	output logic [W-1:0]             root
);

	localparam int FULL  = 1 << (2 * LEVELS);
	localparam int INNER = (FULL - 1) / 3;
	localparam int TOTAL = INNER + FULL;

	// heap order: children of node k are 4k+1 .. 4k+4
	logic [W-1:0] tap    [TOTAL];
	logic [W-1:0] node_q [INNER];

	for (genvar j = 0; j < FULL; j++) begin : g_leaf
		if (j < LEAVES) begin : g_used
			assign tap[INNER + j] = leaf[j];
		end else begin : g_pad
			assign tap[INNER + j] = '0;
		end
	end

	for (genvar k = 0; k < INNER; k++) begin : g_node
		assign tap[k] = node_q[k];
		always_ff @(posedge clk) begin
			node_q[k] <= tap[4*k+1] | tap[4*k+2] | tap[4*k+3] | tap[4*k+4];
		end
	end

	assign root = node_q[0];

endmodule

@@ hdl/indexed_shift_list_core.sv @@
// Top level: operation decode, count, row of entry cells and read gather.
// Results: done strobes for a request once it has passed the cell's read register and the
// registered OR tree (LEVELS = ceil(log4(CAPACITY))) that gathers a get's read.
// Throughput: one request per cycle; every shift is done by the whole cell row in a single update.
// busy stays low; the receiver cannot stall, results leave in request order.
// Reset clears the count and the result valid pipeline; entry contents are undefined until written.
module indexed_shift_list_core import isl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  isl_req_t req,
	output logic     done,
	output isl_rsp_t rsp
);

	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int PW     = (CW > INDEX_W) ? CW : INDEX_W;
	localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
	localparam int LAT    = LEVELS + 1;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     cnt_nxt;
	logic [PW-1:0]     cnt_x;
	logic [PW-1:0]     idx_x;
	logic [PW-1:0]     pos;
	isl_cell_ctrl_t    ctrl;
	isl_status_t       sts;
	logic              accept;

	logic              vld_q [LAT];
	isl_status_t       sts_q [LAT];
	logic [COUNT_W-1:0] cnt_pipe_q [LAT];

	logic [CAPACITY-1:0][DATA_W-1:0] data_row;
	logic [CAPACITY-1:0][DATA_W-1:0] leaf_row;
	logic [DATA_W-1:0]               rd_root;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign cnt_x  = PW'(cnt_q);
	assign idx_x  = PW'(req.index);

	always_comb begin
		ctrl.mode = MODE_HOLD;
		ctrl.rd   = 1'b0;
		pos       = idx_x;
		sts       = ST_OK;
		cnt_nxt   = cnt_q;
		if (accept) begin
			case (isl_op_t'(req.op))
				OP_PUSH: begin
					if (cnt_q == CAP_CNT) begin
						sts = ST_FULL;
					end else begin
						ctrl.mode = MODE_WR;
						pos       = cnt_x;
						cnt_nxt   = cnt_q + 1'b1;
					end
				end
				OP_INSERT: begin
					if (idx_x > cnt_x) begin
						sts = ST_BAD_INDEX;
					end else if (cnt_q == CAP_CNT) begin
						sts = ST_FULL;
					end else begin
						ctrl.mode = MODE_INS;
						cnt_nxt   = cnt_q + 1'b1;
					end
				end
				OP_REMOVE: begin
					if (idx_x >= cnt_x) begin
						sts = ST_BAD_INDEX;
					end else begin
						ctrl.mode = MODE_DEL;
						cnt_nxt   = cnt_q - 1'b1;
					end
				end
				OP_POP: begin
					if (cnt_q == '0)
						sts = ST_EMPTY;
					else
						cnt_nxt = cnt_q - 1'b1;
				end
				OP_REPLACE: begin
					if (idx_x >= cnt_x)
						sts = ST_BAD_INDEX;
					else
						ctrl.mode = MODE_WR;
				end
				OP_GET: begin
					if (idx_x >= cnt_x)
						sts = ST_BAD_INDEX;
					else
						ctrl.rd = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int s = 0; s < LAT; s++)
				vld_q[s] <= 1'b0;
		end else begin
			cnt_q    <= cnt_nxt;
			vld_q[0] <= accept;
			for (int s = 1; s < LAT; s++)
				vld_q[s] <= vld_q[s-1];
		end
	end

	// status and count ride alongside the read tree
	always_ff @(posedge clk) begin
		sts_q[0]      <= sts;
		cnt_pipe_q[0] <= COUNT_W'(cnt_nxt);
		for (int s = 1; s < LAT; s++) begin
			sts_q[s]      <= sts_q[s-1];
			cnt_pipe_q[s] <= cnt_pipe_q[s-1];
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = data_row[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = data_row[i+1];
		end
		isl_cell #(
			.PW  (PW),
			.POS (i)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.pos   (pos),
			.value (req.value),
			.left  (left_d),
			.right (right_d),
			.data  (data_row[i]),
			.leaf  (leaf_row[i])
		);
	end

	isl_or_tree #(
		.W      (DATA_W),
		.LEAVES (CAPACITY),
		.LEVELS (LEVELS)
	) u_tree (
		.clk  (clk),
		.leaf (leaf_row),
		.root (rd_root)
	);

	assign done           = vld_q[LAT-1];
	assign rsp.read_value = rd_root;
	assign rsp.status     = sts_q[LAT-1];
	assign rsp.count      = cnt_pipe_q[LAT-1];

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("request did not produce a result on time");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> rsp.count == COUNT_W'(CAPACITY))
		else $error("full status with list not full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_EMPTY) |-> rsp.count == '0)
		else $error("empty status with entries present");
`endif

endmodule

@@ bench/isl_list_checker.sv @@
`timescale 1ns / 100ps
// Checker for the indexed shift list: tracks the list, predicts each response, compares.
module isl_list_checker import isl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  isl_req_t req,
	input  logic     done,
	input  isl_rsp_t rsp,
	output int       failures,
	output int       pending,
	output int       tracked_len
);

	logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
	int shadow_len;
	int fail_cnt;
	isl_rsp_t expected_rsp_q[$];

	// Applies one request to the shadow list and returns the response it should produce
	function automatic isl_rsp_t apply_list_op(isl_req_t r);
		isl_rsp_t res;
		int idx;
		res = '0;
		res.status = ST_OK;
		idx = int'(r.index);
		case (r.op)
			OP_PUSH: begin
				if (shadow_len >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					shadow_entries[shadow_len] = r.value;
					shadow_len++;
				end
			end
			OP_INSERT: begin
				// index check wins over the full check
				if (idx > shadow_len) begin
					res.status = ST_BAD_INDEX;
				end else if (shadow_len >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int i = shadow_len; i > idx; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[idx] = r.value;
					shadow_len++;
				end
			end
			OP_REMOVE: begin
				if (idx >= shadow_len) begin
					res.status = ST_BAD_INDEX;
				end else begin
					for (int i = idx; i + 1 < shadow_len; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_len--;
				end
			end
			OP_POP: begin
				if (shadow_len == 0)
					res.status = ST_EMPTY;
				else
					shadow_len--;
			end
			OP_REPLACE: begin
				if (idx >= shadow_len)
					res.status = ST_BAD_INDEX;
				else
					shadow_entries[idx] = r.value;
			end
			OP_GET: begin
				if (idx >= shadow_len)
					res.status = ST_BAD_INDEX;
				else
					res.read_value = shadow_entries[idx];
			end
			default: begin
				// spare opcodes: no effect, status ok
			end
		endcase
		res.count = COUNT_W'(shadow_len);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		isl_rsp_t exp_rsp;
		if (!arst_n) begin
			expected_rsp_q.delete();
			shadow_len = 0;
			fail_cnt = 0;
			failures <= 0;
			pending <= 0;
			tracked_len <= 0;
		end else begin
			// responses come from earlier requests, so check before queuing this edge's request
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					$error("response with no request outstanding");
					fail_cnt++;
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp.read_value !== exp_rsp.read_value) begin
						$error("read_value: expected %0d, got %0d",
							exp_rsp.read_value, rsp.read_value);
						fail_cnt++;
					end
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
						fail_cnt++;
					end
					if (rsp.count !== exp_rsp.count) begin
						$error("count: expected %0d, got %0d", exp_rsp.count, rsp.count);
						fail_cnt++;
					end
				end
			end
			if (start && !busy)
				expected_rsp_q.push_back(apply_list_op(req));
			failures <= fail_cnt;
			pending <= expected_rsp_q.size();
			tracked_len <= shadow_len;
		end
	end

endmodule

@@ bench/tb_indexed_shift_list_core.sv @@
`timescale 1ns / 100ps
// Testbench top: drives list requests into the core and reports the verdict.
module tb_indexed_shift_list_core;
	import isl_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int INDEX_MAX = (1 << INDEX_W) - 1;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_PCT = 12;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	isl_req_t req;
	isl_rsp_t rsp;
	int       failures;
	int       pending;
	int       tracked_len;
	int       cycles = 0;
	bit       quiet;
	bit       growing;
	int       full_hits;
	int       empty_hits;

	indexed_shift_list_core #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	isl_list_checker #(.CAPACITY(CAPACITY)) u_list_chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.failures(failures),
		.pending(pending),
		.tracked_len(tracked_len)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(19))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly a valid position up to valid_hi, sometimes one past it or anywhere
	function automatic logic [INDEX_W-1:0] pick_index(int valid_hi);
		int roll;
		roll = $urandom_range(99);
		if (valid_hi < 0 || roll >= 93)
			return INDEX_W'($urandom_range(INDEX_MAX));
		if (roll >= 85)
			return INDEX_W'(valid_hi + 1);
		return INDEX_W'($urandom_range(valid_hi));
	endfunction

	// Growing phases fill the list toward full, shrinking phases drain it toward empty
	function automatic isl_req_t pick_request(bit grow, int len);
		isl_req_t r;
		int roll;
		r.value = pick_value();
		r.index = INDEX_W'($urandom_range(INDEX_MAX));
		roll = $urandom_range(99);
		if (grow) begin
			if (roll < 45) r.op = OP_PUSH;
			else if (roll < 85) begin r.op = OP_INSERT; r.index = pick_index(len); end
			else if (roll < 90) begin r.op = OP_GET; r.index = pick_index(len - 1); end
			else if (roll < 93) begin r.op = OP_REPLACE; r.index = pick_index(len - 1); end
			else if (roll < 96) begin r.op = OP_REMOVE; r.index = pick_index(len - 1); end
			else if (roll < 98) r.op = OP_POP;
			else r.op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
		end else begin
			if (roll < 35) begin r.op = OP_REMOVE; r.index = pick_index(len - 1); end
			else if (roll < 70) r.op = OP_POP;
			else if (roll < 80) begin r.op = OP_GET; r.index = pick_index(len - 1); end
			else if (roll < 88) begin r.op = OP_REPLACE; r.index = pick_index(len - 1); end
			else if (roll < 93) begin r.op = OP_INSERT; r.index = pick_index(len); end
			else if (roll < 96) r.op = OP_PUSH;
			else r.op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
		end
		return r;
	endfunction

	task automatic send_request(isl_req_t r);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_op(logic [2:0] op, int idx, logic signed [DATA_W-1:0] val);
		isl_req_t r;
		r.op = op;
		r.index = INDEX_W'(idx);
		r.value = val;
		send_request(r);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		quiet = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty list: pop, and every indexed op is out of range
		send_op(OP_POP, 0, 32'sd5);
		send_op(OP_GET, 0, 32'sd0);
		send_op(OP_REMOVE, 0, 32'sd0);
		send_op(OP_REPLACE, 0, 32'sd9);
		send_op(OP_INSERT, 1, 32'sd7);
		// build a short list with extreme values, inserts at head, tail and middle
		send_op(OP_INSERT, 0, 32'sh7fff_ffff);
		send_op(OP_PUSH, 0, 32'sh8000_0000);
		send_op(OP_PUSH, INDEX_MAX, 32'sd0);
		send_op(OP_PUSH, 0, -32'sd1);
		send_op(OP_INSERT, 4, 32'sh5555_5555);
		send_op(OP_INSERT, 2, 32'shaaaa_aaaa);
		send_op(OP_INSERT, INDEX_MAX, 32'sd3);
		send_op(OP_GET, 5, 32'sd0);
		send_op(OP_GET, 6, 32'sd0);
		send_op(OP_GET, 256, 32'sd0);
		send_op(OP_REPLACE, 0, 32'sh1234_5678);
		send_op(OP_REPLACE, 300, 32'sd1);
		send_op(OP_GET, 0, 32'sd0);
		send_op(OP_REMOVE, 2, 32'sd0);
		send_op(OP_REMOVE, 4, 32'sd0);
		send_op(OP_REMOVE, 256, 32'sd0);
		send_op(OP_SPARE_6, INDEX_MAX, -32'sd1);
		send_op(OP_SPARE_7, 0, 32'sd0);
		send_op(OP_POP, 0, 32'sd0);
		send_op(OP_GET, 0, 32'sd0);

		growing = 1'b1;
		full_hits = 0;
		empty_hits = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 200 && n < 320);
			if (growing && tracked_len >= CAPACITY && ++full_hits > 12) begin
				growing = 1'b0;
				full_hits = 0;
			end else if (!growing && tracked_len == 0 && ++empty_hits > 6) begin
				growing = 1'b1;
				empty_hits = 0;
			end
			send_request(pick_request(growing, tracked_len));
		end
		start <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
hdl/isl_pkg.sv
hdl/isl_cell.sv
hdl/isl_or_tree.sv
hdl/indexed_shift_list_core.sv
bench/isl_list_checker.sv
bench/tb_indexed_shift_list_core.sv
